// ===== rtl/core/rbsi_pkg.sv =====
// Shared types, widths and register codes for the ray/box slab test.
// Used by rbsi_div_pipe and ray_box_slab_intersect; depends on nothing.
`default_nettype none
package rbsi_pkg;

    localparam int COORD_BITS = 32;
    localparam int FRAC_BITS  = 16;
    localparam int W          = COORD_BITS;
    localparam int NW         = COORD_BITS + 1;   // numerator magnitude
    localparam int QW         = COORD_BITS + 1;   // quotient bits kept
    localparam int LANES      = 6;                // lo x/y/z, hi x/y/z
    localparam int AXES       = 3;
    localparam int IDX_BITS   = 3;

    localparam int IN_BITS    = LANES * W;
    localparam int OUT_RAW    = 1 + 2 * W;
    localparam int OUT_BITS   = ((OUT_RAW + 7) / 8) * 8;

    // configuration register indexes
    localparam logic [IDX_BITS-1:0] REG_ORIGIN_X = 3'd0;
    localparam logic [IDX_BITS-1:0] REG_ORIGIN_Y = 3'd1;
    localparam logic [IDX_BITS-1:0] REG_ORIGIN_Z = 3'd2;
    localparam logic [IDX_BITS-1:0] REG_DIR_X    = 3'd3;
    localparam logic [IDX_BITS-1:0] REG_DIR_Y    = 3'd4;
    localparam logic [IDX_BITS-1:0] REG_DIR_Z    = 3'd5;
    localparam logic [IDX_BITS-1:0] REG_NEAR     = 3'd6;
    localparam logic [IDX_BITS-1:0] REG_FAR      = 3'd7;

    localparam logic [W-1:0]  S_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0]  S_MIN = {1'b1, {(W-1){1'b0}}};
    localparam logic [QW-1:0] Q_HALF = QW'(1) << (W - 1);

    // per-item flags carried alongside the divider lanes
    typedef struct packed {
        logic             pass;
        logic [AXES-1:0]  dneg;
        logic [AXES-1:0]  dzero;
        logic [LANES-1:0] neg;
        logic [LANES-1:0] ovf;
    } side_t;

    // one restoring division step: {quotient bit, next remainder}
    function automatic logic [W:0] div_step(input logic [W-1:0] rem,
                                            input logic nb,
                                            input logic [W-1:0] den);
        logic [W:0] trial;
        logic [W:0] diff;
        trial = {rem, nb};
        diff  = trial - {1'b0, den};
        if (trial >= {1'b0, den}) begin
            return {1'b1, diff[W-1:0]};
        end else begin
            return {1'b0, trial[W-1:0]};
        end
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/rbsi_div_pipe.sv =====
// Six-lane pipelined restoring divider, one quotient bit per stage.
// Depends on rbsi_pkg.
`default_nettype none
module rbsi_div_pipe (
    input  wire logic                                              aclk,
    input  wire logic                                              aresetn,
    input  wire logic                                              in_valid,
    output logic                                                   in_ready,
    input  wire logic [rbsi_pkg::LANES-1:0][rbsi_pkg::NW-1:0]      in_num,
    input  wire logic [rbsi_pkg::LANES-1:0][rbsi_pkg::W-1:0]       in_den,
    input  wire rbsi_pkg::side_t                                   in_side,
    output logic                                                   out_valid,
    input  wire logic                                              out_ready,
    output logic [rbsi_pkg::LANES-1:0][rbsi_pkg::QW-1:0]           out_q,
    output rbsi_pkg::side_t                                        out_side
);
    localparam int S = rbsi_pkg::QW;

    logic [S-1:0] v_reg;
    logic [S-1:0] en;
    logic [rbsi_pkg::LANES-1:0][rbsi_pkg::W-1:0]  rem_reg  [S];
    logic [rbsi_pkg::LANES-1:0][rbsi_pkg::QW-1:0] q_reg    [S];
    logic [rbsi_pkg::LANES-1:0][rbsi_pkg::NW-1:0] num_reg  [S];
    logic [rbsi_pkg::LANES-1:0][rbsi_pkg::W-1:0]  den_reg  [S];
    rbsi_pkg::side_t                              side_reg [S];

    for (genvar s = 0; s < S; s++) begin : g_stage
        localparam int P = S - 1 - s;   // quotient bit made here
        logic                                         v_in;
        logic [rbsi_pkg::LANES-1:0][rbsi_pkg::W-1:0]  rem_in;
        logic [rbsi_pkg::LANES-1:0][rbsi_pkg::QW-1:0] q_in;
        logic [rbsi_pkg::LANES-1:0][rbsi_pkg::NW-1:0] num_in;
        logic [rbsi_pkg::LANES-1:0][rbsi_pkg::W-1:0]  den_in;
        rbsi_pkg::side_t                              side_in;
        logic [rbsi_pkg::LANES-1:0][rbsi_pkg::W-1:0]  rem_next;
        logic [rbsi_pkg::LANES-1:0][rbsi_pkg::QW-1:0] q_next;

        if (s == 0) begin : g_first
            always_comb begin
                v_in    = in_valid;
                num_in  = in_num;
                den_in  = in_den;
                side_in = in_side;
                q_in    = '0;
                for (int l = 0; l < rbsi_pkg::LANES; l++) begin
                    // dividend bits above the kept quotient range
                    rem_in[l] = rbsi_pkg::W'(in_num[l] >> (rbsi_pkg::QW - rbsi_pkg::FRAC_BITS));
                end
            end
        end else begin : g_rest
            always_comb begin
                v_in    = v_reg[s-1];
                num_in  = num_reg[s-1];
                den_in  = den_reg[s-1];
                side_in = side_reg[s-1];
                q_in    = q_reg[s-1];
                rem_in  = rem_reg[s-1];
            end
        end

        if (s == S - 1) begin : g_en_last
            assign en[s] = !v_reg[s] || out_ready;
        end else begin : g_en_mid
            assign en[s] = !v_reg[s] || en[s+1];
        end

        // one division step on every lane
        always_comb begin
            logic [rbsi_pkg::W:0] st;
            logic                 nb;
            for (int l = 0; l < rbsi_pkg::LANES; l++) begin
                if (P >= rbsi_pkg::FRAC_BITS) begin
                    nb = num_in[l][(P >= rbsi_pkg::FRAC_BITS) ? P - rbsi_pkg::FRAC_BITS : 0];
                end else begin
                    nb = 1'b0;
                end
                st          = rbsi_pkg::div_step(rem_in[l], nb, den_in[l]);
                rem_next[l] = st[rbsi_pkg::W-1:0];
                q_next[l]   = {q_in[l][rbsi_pkg::QW-2:0], st[rbsi_pkg::W]};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[s] <= 1'b0;
            end else if (en[s]) begin
                v_reg[s] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en[s]) begin
                rem_reg[s]  <= rem_next;
                q_reg[s]    <= q_next;
                num_reg[s]  <= num_in;
                den_reg[s]  <= den_in;
                side_reg[s] <= side_in;
            end
        end
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[S-1];
    assign out_q     = q_reg[S-1];
    assign out_side  = side_reg[S-1];

endmodule
`default_nettype wire

// ===== rtl/core/ray_box_slab_intersect.sv =====
// Ray versus axis-aligned box slab test, one box per transfer.
// Stages from input transfer to m_axis_tvalid: 2 prep stages,
// 33 divider stages of one quotient bit each, 3 reduce/compare stages.
// Throughput: one box per cycle; each stage holds only when it is full and
// the stage after it is stalled. Synchronous active-low reset clears all
// valid bits and loads the ray registers (far bound to max, others to 0).
// Depends on rbsi_pkg and rbsi_div_pipe.
`default_nettype none
module ray_box_slab_intersect (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // configuration writes
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [rbsi_pkg::IDX_BITS-1:0]     cfg_index,
    input  wire logic [rbsi_pkg::W-1:0]            cfg_data,
    // boxes in
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // box_lo_x, box_lo_y, box_lo_z, box_hi_x, box_hi_y, box_hi_z
    input  wire logic [rbsi_pkg::IN_BITS-1:0]      s_axis_tdata,
    // results out
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // hit, t_entry, t_leave, zero pad
    output logic [rbsi_pkg::OUT_BITS-1:0]          m_axis_tdata
);
    localparam int W = rbsi_pkg::W;
    localparam int L = rbsi_pkg::LANES;
    localparam int A = rbsi_pkg::AXES;

    // ray registers
    logic [A-1:0][W-1:0] org_reg;
    logic [A-1:0][W-1:0] dir_reg;
    logic [W-1:0]        near_reg;
    logic [W-1:0]        far_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            org_reg  <= '0;
            dir_reg  <= '0;
            near_reg <= '0;
            far_reg  <= rbsi_pkg::S_MAX;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                rbsi_pkg::REG_ORIGIN_X: org_reg[0] <= cfg_data;
                rbsi_pkg::REG_ORIGIN_Y: org_reg[1] <= cfg_data;
                rbsi_pkg::REG_ORIGIN_Z: org_reg[2] <= cfg_data;
                rbsi_pkg::REG_DIR_X:    dir_reg[0] <= cfg_data;
                rbsi_pkg::REG_DIR_Y:    dir_reg[1] <= cfg_data;
                rbsi_pkg::REG_DIR_Z:    dir_reg[2] <= cfg_data;
                rbsi_pkg::REG_NEAR:     near_reg   <= cfg_data;
                rbsi_pkg::REG_FAR:      far_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // stage handshake chain
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic en1, en2, en3, en4, en5;
    logic div_in_ready, div_out_valid;

    assign en5 = !v5_reg || m_axis_tready;
    assign en4 = !v4_reg || en5;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || div_in_ready;
    assign en1 = !v1_reg || en2;
    assign s_axis_tready = en1;

    // stage 1: slab differences, magnitudes, signs, zero-axis check
    logic [L-1:0][rbsi_pkg::NW-1:0] n1_next, n1_reg;
    logic [L-1:0][W-1:0]            d1_next, d1_reg;
    rbsi_pkg::side_t                side1_next, side1_reg;

    always_comb begin
        logic [W-1:0]            a;
        logic [W-1:0]            o;
        logic [W-1:0]            dr;
        logic [rbsi_pkg::NW-1:0] df;
        logic                    nneg;
        int                      ax;
        side1_next      = '0;
        side1_next.pass = 1'b1;
        for (int l = 0; l < L; l++) begin
            ax   = (l < A) ? l : l - A;
            a    = s_axis_tdata[l*W +: W];
            o    = org_reg[ax];
            dr   = dir_reg[ax];
            df   = {a[W-1], a} - {o[W-1], o};
            nneg = df[rbsi_pkg::NW-1];
            n1_next[l] = nneg ? (~df + 1'b1) : df;
            d1_next[l] = dr[W-1] ? (~dr + 1'b1) : dr;
            side1_next.neg[l] = nneg ^ dr[W-1];
        end
        for (int x = 0; x < A; x++) begin
            side1_next.dneg[x]  = dir_reg[x][W-1];
            side1_next.dzero[x] = (dir_reg[x] == '0);
            if (dir_reg[x] == '0 &&
                ($signed(org_reg[x]) < $signed(s_axis_tdata[x*W +: W]) ||
                 $signed(org_reg[x]) > $signed(s_axis_tdata[(x+A)*W +: W]))) begin
                side1_next.pass = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en1) begin
            v1_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            n1_reg    <= n1_next;
            d1_reg    <= d1_next;
            side1_reg <= side1_next;
        end
    end

    // stage 2: quotient overflow check (n * 2^16 / d needs more than QW bits)
    logic [L-1:0][rbsi_pkg::NW-1:0] n2_reg;
    logic [L-1:0][W-1:0]            d2_reg;
    rbsi_pkg::side_t                side2_next, side2_reg;

    always_comb begin
        side2_next = side1_reg;
        for (int l = 0; l < L; l++) begin
            side2_next.ovf[l] = (n1_reg[l] >> (rbsi_pkg::QW - rbsi_pkg::FRAC_BITS))
                                >= rbsi_pkg::NW'(d1_reg[l]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en2) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en2) begin
            n2_reg    <= n1_reg;
            d2_reg    <= d1_reg;
            side2_reg <= side2_next;
        end
    end

    // divider
    logic [L-1:0][rbsi_pkg::QW-1:0] q_div;
    rbsi_pkg::side_t                side_div;

    rbsi_div_pipe u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (v2_reg),
        .in_ready  (div_in_ready),
        .in_num    (n2_reg),
        .in_den    (d2_reg),
        .in_side   (side2_reg),
        .out_valid (div_out_valid),
        .out_ready (en3),
        .out_q     (q_div),
        .out_side  (side_div)
    );

    // stage 3: saturate, apply sign, order entry/exit per axis
    logic [A-1:0][W-1:0] ent3_next, ent3_reg, lv3_next, lv3_reg;
    logic [A-1:0]        dz3_reg;
    logic                pass3_reg;

    always_comb begin
        logic [L-1:0][W-1:0]     t;
        logic [rbsi_pkg::QW-1:0] lim;
        logic [rbsi_pkg::QW-1:0] qc;
        logic [rbsi_pkg::QW-1:0] qs;
        for (int l = 0; l < L; l++) begin
            lim  = side_div.neg[l] ? rbsi_pkg::Q_HALF : rbsi_pkg::Q_HALF - 1'b1;
            qc   = (side_div.ovf[l] || q_div[l] > lim) ? lim : q_div[l];
            qs   = side_div.neg[l] ? (~qc + 1'b1) : qc;
            t[l] = qs[W-1:0];
        end
        for (int x = 0; x < A; x++) begin
            ent3_next[x] = side_div.dneg[x] ? t[x+A] : t[x];
            lv3_next[x]  = side_div.dneg[x] ? t[x] : t[x+A];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en3) begin
            v3_reg <= div_out_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en3) begin
            ent3_reg  <= ent3_next;
            lv3_reg   <= lv3_next;
            dz3_reg   <= side_div.dzero;
            pass3_reg <= side_div.pass;
        end
    end

    // stage 4: largest entry and smallest exit over bounding axes
    logic [W-1:0] ent4_next, ent4_reg, lv4_next, lv4_reg;
    logic         pass4_reg;

    always_comb begin
        ent4_next = rbsi_pkg::S_MIN;
        lv4_next  = rbsi_pkg::S_MAX;
        for (int x = 0; x < A; x++) begin
            if (!dz3_reg[x]) begin
                if ($signed(ent3_reg[x]) > $signed(ent4_next)) begin
                    ent4_next = ent3_reg[x];
                end
                if ($signed(lv3_reg[x]) < $signed(lv4_next)) begin
                    lv4_next = lv3_reg[x];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (en4) begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en4) begin
            ent4_reg  <= ent4_next;
            lv4_reg   <= lv4_next;
            pass4_reg <= pass3_reg;
        end
    end

    // stage 5: interval overlap, output register
    logic         hit5_next, hit5_reg;
    logic [W-1:0] ent5_reg, lv5_reg;

    assign hit5_next = pass4_reg &&
                       ($signed(ent4_reg) <= $signed(lv4_reg)) &&
                       ($signed(ent4_reg) <  $signed(far_reg)) &&
                       ($signed(lv4_reg)  >= $signed(near_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg <= 1'b0;
        end else if (en5) begin
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en5) begin
            hit5_reg <= hit5_next;
            ent5_reg <= ent4_reg;
            lv5_reg  <= lv4_reg;
        end
    end

    assign m_axis_tvalid = v5_reg;
    assign m_axis_tdata  = rbsi_pkg::OUT_BITS'({lv5_reg, ent5_reg, hit5_reg});

    // checks
    a_hit_ordered: assert property (@(posedge aclk) disable iff (!aresetn)
        v5_reg && hit5_reg |-> $signed(ent5_reg) <= $signed(lv5_reg))
        else $error("hit reported with entry after exit");

    a_hit_far: assert property (@(posedge aclk) disable iff (!aresetn)
        v5_reg && hit5_reg |-> $signed(ent5_reg) < $signed(far_reg))
        else $error("hit reported with entry beyond far bound");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid && !v1_reg)
        else $error("pipeline not empty after reset");

    a_ready_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !v1_reg |-> s_axis_tready)
        else $error("input stalled with empty first stage");

endmodule
`default_nettype wire
